// ----- sv/pwpm_pkg.sv -----
package pwpm_pkg;

    localparam int NUM_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [NUM_BITS-1:0] VOLTAGE_NUM_RESET = 32'd165732000;
    localparam logic [NUM_BITS-1:0] POWER_NUM_RESET = 32'd2097540000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_VOLTAGE_NUM = 2'd0,
        CFG_POWER_NUM   = 2'd1
    } t_cfg_index;

    localparam logic KIND_VOLTAGE = 1'b0;
    localparam logic KIND_POWER = 1'b1;

    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- sv/pwpm_div.sv -----
module pwpm_div #(
    parameter int DIV_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pwpm_pkg::t_div_ctl             i_ctl,
    input  logic [pwpm_pkg::NUM_BITS-1:0]  i_numerator,
    input  logic [DIV_BITS-1:0]            i_divisor,
    output pwpm_pkg::t_div_sts             o_sts,
    output logic [pwpm_pkg::NUM_BITS-1:0]  o_quotient
);
    import pwpm_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [DIV_BITS:0]     r_rem, n_rem;
    logic [NUM_BITS-1:0]   r_quo, n_quo;
    logic [DIV_BITS-1:0]   r_den, n_den;

    logic [DIV_BITS:0]     w_shift;
    logic [DIV_BITS+1:0]   w_diff;

    // One quotient bit per cycle, restoring division.
    assign w_shift = {r_rem[DIV_BITS-1:0], r_quo[NUM_BITS-1]};
    assign w_diff = {1'b0, w_shift} - {2'b00, r_den};

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_state = S_RUN;
                    n_cnt = CNT_BITS'(NUM_BITS - 1);
                    n_rem = '0;
                    n_quo = i_numerator;
                    n_den = i_divisor;
                end
            end
            S_RUN: begin
                if (w_diff[DIV_BITS+1]) begin
                    n_rem = w_shift;
                    n_quo = {r_quo[NUM_BITS-2:0], 1'b0};
                end else begin
                    n_rem = w_diff[DIV_BITS:0];
                    n_quo = {r_quo[NUM_BITS-2:0], 1'b1};
                end
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_sts.busy = (r_state == S_RUN);
    assign o_sts.done = (r_state == S_DONE);
    assign o_quotient = r_quo;

endmodule

// ----- sv/pulse_width_power_meter.sv -----
// An input beat that completes a pulse starts a bit-serial division; input is held off
// until its reading has moved from the divider's done state into the output register.
// Other beats start no division; while none is pending a new beat may follow every cycle.
// A finished reading waits in an output register while further beats are taken.
// Synchronous active-low reset restores the register defaults and rearms on voltage.
module pulse_width_power_meter #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_voltage_pulse_level,
    input  logic                                  i_power_pulse_level,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_reading_kind,
    output logic [pwpm_pkg::NUM_BITS-1:0]         o_reading_value,
    input  logic                                  i_cfg_we,
    input  logic [pwpm_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [pwpm_pkg::NUM_BITS-1:0]         i_cfg_data
);
    import pwpm_pkg::*;

    logic [NUM_BITS-1:0]   r_vnum, r_pnum;
    logic                  r_sel, r_in_pulse;
    logic [1:0]            r_prev;
    logic [COUNT_BITS-1:0] r_high, n_high;
    logic                  n_sel, n_in_pulse;
    logic                  r_pend_kind;
    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [NUM_BITS-1:0]   r_out_value;

    logic [1:0]            w_levels;
    logic                  w_accept, w_now, w_before, w_fire;
    t_div_ctl              w_ctl;
    t_div_sts              w_sts;
    logic [NUM_BITS-1:0]   w_quotient;

    assign w_levels = {i_power_pulse_level, i_voltage_pulse_level};
    assign o_ready = !w_sts.busy && !w_sts.done;
    assign w_accept = i_valid && o_ready;
    assign w_now = w_levels[r_sel];
    assign w_before = r_prev[r_sel];
    assign w_fire = w_accept && r_in_pulse && !w_now && (r_high != '0);

    always_comb begin
        n_sel = r_sel;
        n_in_pulse = r_in_pulse;
        n_high = r_high;
        if (!r_in_pulse) begin
            if (w_now && !w_before) begin
                n_in_pulse = 1'b1;
                n_high = COUNT_BITS'(1);
            end
        end else if (w_now) begin
            if (r_high != '1) begin
                n_high = r_high + 1'b1;
            end
        end else begin
            n_in_pulse = 1'b0;
            n_high = '0;
            if (r_high != '0) begin
                n_sel = !r_sel;
            end
        end
    end

    assign w_ctl.start = w_fire;
    assign w_ctl.take = w_sts.done && (!r_out_valid || i_ready);

    pwpm_div #(
        .DIV_BITS (COUNT_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_numerator (r_sel ? r_pnum : r_vnum),
        .i_divisor   (r_high),
        .o_sts       (w_sts),
        .o_quotient  (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vnum <= VOLTAGE_NUM_RESET;
            r_pnum <= POWER_NUM_RESET;
            r_sel <= KIND_VOLTAGE;
            r_in_pulse <= 1'b0;
            r_prev <= 2'b00;
            r_high <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_VOLTAGE_NUM) begin
                    r_vnum <= i_cfg_data;
                end else if (i_cfg_index == CFG_POWER_NUM) begin
                    r_pnum <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_sel <= n_sel;
                r_in_pulse <= n_in_pulse;
                r_high <= n_high;
                r_prev <= w_levels;
            end
            if (w_ctl.take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_pend_kind <= r_sel;
        end
        if (w_ctl.take) begin
            r_out_kind <= r_pend_kind;
            r_out_value <= w_quotient;
        end
    end

    assign o_valid = r_out_valid;
    assign o_reading_kind = r_out_kind;
    assign o_reading_value = r_out_value;

endmodule
